[hw/rtl/ahrb_pkg.sv]
// Shared types, codes and constants of the audio history ring buffer.
package ahrb_pkg;

    localparam int DEPTH       = 32768;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = 16;
    localparam int RATE_W      = 18;
    localparam int MS_W        = 14;
    localparam int IDX_W       = 15;
    localparam int WORD_W      = 32;
    localparam int ACT_W       = 3;
    localparam int STAT_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int PROD_W      = RATE_W + MS_W;
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 38;
    localparam int SCALED_W    = PROD_W + RECIP_W;
    localparam int QUOT_W      = SCALED_W - RECIP_SHIFT;

    // ceil(2^38 / 1000): exact quotient by 1000 for every 32-bit dividend.
    localparam logic [RECIP_W-1:0] RECIP_1000 = 29'h10624DD3;

    localparam logic [RATE_W-1:0] RATE_RESET   = 18'd16000;
    localparam logic [MS_W-1:0]   WINDOW_RESET = 14'd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_RATE = 2'd0,
        CFG_WINDOW_MS   = 2'd1
    } t_cfg_reg;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE  = 3'd0,
        ACT_READ   = 3'd1,
        ACT_CLEAR  = 3'd2,
        ACT_RESUME = 3'd3,
        ACT_PAUSE  = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK             = 3'd0,
        ST_NOT_RUNNING    = 3'd1,
        ST_ALREADY_RUN    = 3'd2,
        ST_ALREADY_PAUSED = 3'd3,
        ST_INDEX_OUT      = 3'd4
    } t_status;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [WORD_W-1:0] sample_in;
        logic [MS_W-1:0]   span_ms;
        logic [IDX_W-1:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] sample_out;
        logic [CNT_W-1:0]  span_count;
    } t_out_item;

    typedef struct packed {
        logic    cfg_en;
        logic    ld_item;
        logic    sel_span;
        logic    ld_cap;
        logic    ld_n;
        logic    mem_wr;
        logic    ring_clr;
        logic    ld_addr;
        logic    mem_rd;
        logic    res_ld;
        t_status res_status;
        logic    res_count_en;
        logic    out_load;
        logic    out_data_en;
    } t_dp_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             idx_out;
    } t_dp_stat;

endpackage

[hw/rtl/audio_history_ring_buffer.sv]
// Top level of the audio history ring buffer: controller plus datapath.
//
//   Channel  Direction  Handshake                     Payload
//   in       to block   i_in_valid / o_in_stall       i_in_data   (t_in_item)
//   out      from block o_out_valid / i_out_stall     o_out_data  (t_out_item)
//   cfg      to block   i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// Every transaction on the input yields exactly one result transaction, and no new one
// is accepted until the last has gone through all its steps. The time an item takes is
// set by the two-stage reciprocal multiplier that turns milliseconds into sample counts,
// which each item passes once for the capacity and a read that runs passes a second time
// for its span, plus the registered read port of the history memory on a successful read.
// Reset is synchronous and active low. It clears the position, fill count, run flag
// and registers; the history memory is not cleared, so there is no clearing pass.
// A result waits in the output register while the next input transaction is accepted;
// only the final step of that next item waits if the earlier result is still stalled.
module audio_history_ring_buffer import ahrb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RATE_W-1:0]    i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // The controller walks each item through capacity, execute and output steps, a read that
    // runs also through span and, in range, read steps; it owns the run flag and output valid.
    ahrb_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (dp_cmd)
    );

    // The datapath holds the registers, the ring position and fill, the history memory
    // and the result register. A register write empties the ring since capacity moves.
    ahrb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (dp_stat),
        .o_out_data  (o_out_data)
    );

    // A new result is never loaded over one that is still stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("result register loaded while a stalled result is pending");

    // Loading the result register raises the output valid in the next cycle.
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |=> o_out_valid)
        else $error("output valid missing after result load");

    // Once an input transaction is accepted the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted transaction");

    // The memory port and the ring clear are never used together.
    a_one_ring_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.mem_wr, dp_cmd.mem_rd, dp_cmd.ring_clr}))
        else $error("conflicting ring operations in one cycle");

endmodule

[hw/rtl/ahrb_datapath.sv]
// Datapath of the ring buffer: registers, reciprocal multiplier, ring memory, result register.
module ahrb_datapath import ahrb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  t_in_item             i_in_data,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RATE_W-1:0]    i_cfg_data,
    output t_dp_stat             o_stat,
    output t_out_item            o_out_data
);

    logic [WORD_W-1:0] r_mem [DEPTH];

    t_in_item            r_item;
    logic [RATE_W-1:0]   r_rate;
    logic [MS_W-1:0]     r_window;
    logic [ADDR_W-1:0]   r_wp;
    logic [CNT_W-1:0]    r_fill;
    logic [CNT_W-1:0]    r_cap;
    logic [CNT_W-1:0]    r_n;
    logic [PROD_W-1:0]   r_p1;
    logic [SCALED_W-1:0] r_p2;
    logic [ADDR_W-1:0]   r_addr;
    logic [WORD_W-1:0]   r_rdata;
    t_status             r_res_status;
    logic [CNT_W-1:0]    r_res_count;
    t_out_item           r_out;

    logic [MS_W-1:0]   span_eff;
    logic [MS_W-1:0]   ms_sel;
    logic [QUOT_W-1:0] quot;
    logic [CNT_W-1:0]  cap_new;
    logic [CNT_W-1:0]  n_by_fill;
    logic [CNT_W-1:0]  n_new;
    logic [ADDR_W-1:0] wp_eff;
    logic [CNT_W-1:0]  wp_inc;
    logic [ADDR_W-1:0] wp_next;
    logic [CNT_W:0]    addr_sum;
    logic [CNT_W:0]    addr_wrap;
    logic              cfg_we;

    assign span_eff = (r_item.span_ms == '0) ? r_window : r_item.span_ms;
    assign ms_sel   = i_cmd.sel_span ? span_eff : r_window;
    assign quot     = r_p2[SCALED_W-1:RECIP_SHIFT];

    always_comb begin
        if (quot > QUOT_W'(DEPTH)) begin
            cap_new = CNT_W'(DEPTH);
        end else if (quot == '0) begin
            cap_new = CNT_W'(1);
        end else begin
            cap_new = quot[CNT_W-1:0];
        end
    end

    always_comb begin
        n_by_fill = (quot > QUOT_W'(r_fill)) ? r_fill : quot[CNT_W-1:0];
        n_new     = (n_by_fill > r_cap) ? r_cap : n_by_fill;
    end

    assign wp_eff  = ({1'b0, r_wp} >= r_cap) ? '0 : r_wp;
    assign wp_inc  = {1'b0, wp_eff} + CNT_W'(1);
    assign wp_next = (wp_inc >= r_cap) ? '0 : wp_inc[ADDR_W-1:0];

    // Offset below cap plus a position below cap: one conditional subtract wraps it.
    assign addr_sum  = (CNT_W+1)'(wp_eff) + (CNT_W+1)'(r_cap - r_n)
                     + (CNT_W+1)'(r_item.read_index);
    assign addr_wrap = (addr_sum >= {1'b0, r_cap}) ? addr_sum - {1'b0, r_cap} : addr_sum;

    assign cfg_we = i_cfg_valid && i_cmd.cfg_en;

    assign o_stat.action  = r_item.action;
    assign o_stat.idx_out = ({1'b0, r_item.read_index} >= r_n);
    assign o_out_data     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= RATE_RESET;
            r_window <= WINDOW_RESET;
            r_wp     <= '0;
            r_fill   <= '0;
        end else begin
            if (cfg_we && (i_cfg_index == CFG_SAMPLE_RATE)) begin
                r_rate <= i_cfg_data;
                r_wp   <= '0;
                r_fill <= '0;
            end else if (cfg_we && (i_cfg_index == CFG_WINDOW_MS)) begin
                r_window <= i_cfg_data[MS_W-1:0];
                r_wp     <= '0;
                r_fill   <= '0;
            end else if (i_cmd.ring_clr) begin
                r_wp   <= '0;
                r_fill <= '0;
            end else if (i_cmd.mem_wr) begin
                r_wp   <= wp_next;
                r_fill <= (r_fill < r_cap) ? r_fill + CNT_W'(1) : r_cap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1 <= r_rate * ms_sel;
        r_p2 <= r_p1 * RECIP_1000;
        if (i_cmd.ld_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.ld_cap) begin
            r_cap <= cap_new;
        end
        if (i_cmd.ld_n) begin
            r_n <= n_new;
        end
        if (i_cmd.ld_addr) begin
            r_addr <= addr_wrap[ADDR_W-1:0];
        end
        if (i_cmd.res_ld) begin
            r_res_status <= i_cmd.res_status;
            r_res_count  <= i_cmd.res_count_en ? r_n : '0;
        end
        if (i_cmd.out_load) begin
            r_out.status     <= r_res_status;
            r_out.sample_out <= i_cmd.out_data_en ? r_rdata : '0;
            r_out.span_count <= r_res_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[wp_eff] <= r_item.sample_in;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[r_addr];
        end
    end

endmodule

[hw/rtl/ahrb_controller.sv]
// Sequencing state machine of the ring buffer: item steps, run flag and output valid.
module ahrb_controller import ahrb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output logic     o_cfg_ready,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAP0,
        S_CAP1,
        S_CAP2,
        S_SPAN1,
        S_SPAN2,
        S_EXEC,
        S_READ,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_running, n_running;
    logic   r_out_valid, n_out_valid;
    logic   r_rd_ok, n_rd_ok;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_running   = r_running;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.res_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                o_cmd.cfg_en = 1'b1;
                if (i_in_valid) begin
                    o_cmd.ld_item = 1'b1;
                    n_state       = S_CAP0;
                end
            end
            S_CAP0: n_state = S_CAP1;
            S_CAP1: n_state = S_CAP2;
            S_CAP2: begin
                o_cmd.ld_cap   = 1'b1;
                o_cmd.sel_span = 1'b1;
                if ((i_stat.action == ACT_READ) && r_running) begin
                    n_state = S_SPAN1;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_SPAN1: n_state = S_SPAN2;
            S_SPAN2: begin
                o_cmd.ld_n = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.res_ld = 1'b1;
                n_rd_ok      = 1'b0;
                n_state      = S_OUT;
                case (i_stat.action)
                    ACT_WRITE: begin
                        if (!r_running) begin
                            o_cmd.res_status = ST_NOT_RUNNING;
                        end else begin
                            o_cmd.mem_wr = 1'b1;
                        end
                    end
                    ACT_READ: begin
                        if (!r_running) begin
                            o_cmd.res_status = ST_NOT_RUNNING;
                        end else if (i_stat.idx_out) begin
                            o_cmd.res_status   = ST_INDEX_OUT;
                            o_cmd.res_count_en = 1'b1;
                        end else begin
                            o_cmd.res_count_en = 1'b1;
                            o_cmd.ld_addr      = 1'b1;
                            n_rd_ok            = 1'b1;
                            n_state            = S_READ;
                        end
                    end
                    ACT_CLEAR: begin
                        if (!r_running) begin
                            o_cmd.res_status = ST_NOT_RUNNING;
                        end else begin
                            o_cmd.ring_clr = 1'b1;
                        end
                    end
                    ACT_RESUME: begin
                        if (r_running) begin
                            o_cmd.res_status = ST_ALREADY_RUN;
                        end else begin
                            n_running = 1'b1;
                        end
                    end
                    ACT_PAUSE: begin
                        if (!r_running) begin
                            o_cmd.res_status = ST_ALREADY_PAUSED;
                        end else begin
                            n_running = 1'b0;
                        end
                    end
                    default: o_cmd.res_status = ST_OK;
                endcase
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load    = 1'b1;
                    o_cmd.out_data_en = r_rd_ok;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_ok     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
            r_rd_ok     <= n_rd_ok;
        end
    end

endmodule

[verif/ring_history_checker.sv]
// Checker that predicts and compares every result of the audio history ring buffer.
`timescale 1ns / 100ps

module ring_history_checker import ahrb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RATE_W-1:0]    i_cfg_data,
    output int unsigned          o_pending,
    output int unsigned          o_fails
);

    localparam int unsigned MS_PER_SEC  = 1000;
    localparam int unsigned PRINT_LIMIT = 100;

    // Shadow copy of the ring, its pointers and the two registers.
    logic [WORD_W-1:0] hist [DEPTH];
    int unsigned       wr_pos;
    int unsigned       fill_cnt;
    bit                running;
    logic [RATE_W-1:0] rate_reg;
    logic [MS_W-1:0]   window_reg;
    t_out_item         due_results [$];

    function automatic int unsigned ms_to_samples(input logic [MS_W-1:0] ms);
        longint unsigned prod;
        prod = 64'(rate_reg) * 64'(ms);
        return 32'(prod / MS_PER_SEC);
    endfunction

    task automatic report(input string msg);
        o_fails++;
        if (o_fails <= PRINT_LIMIT) begin
            $display("%0t ns mismatch: %s", $realtime, msg);
        end
    endtask

    // Applies one accepted transaction to the shadow state and gives its result.
    task automatic apply_ring_item(input t_in_item it, output t_out_item res);
        int unsigned cap;
        int unsigned n;
        int unsigned addr;
        cap = ms_to_samples(window_reg);
        if (cap > DEPTH) cap = DEPTH;
        if (cap < 1) cap = 1;
        res = '0;
        case (it.action)
            ACT_WRITE: begin
                if (!running) begin
                    res.status = ST_NOT_RUNNING;
                end else begin
                    if (wr_pos >= cap) wr_pos = 0;
                    hist[wr_pos] = it.sample_in;
                    wr_pos = (wr_pos + 1 >= cap) ? 0 : wr_pos + 1;
                    if (fill_cnt < cap) fill_cnt++;
                end
            end
            ACT_READ: begin
                if (!running) begin
                    res.status = ST_NOT_RUNNING;
                end else begin
                    n = ms_to_samples((it.span_ms == '0) ? window_reg : it.span_ms);
                    if (n > fill_cnt) n = fill_cnt;
                    if (n > cap) n = cap;
                    res.span_count = CNT_W'(n);
                    if (it.read_index >= n) begin
                        res.status = ST_INDEX_OUT;
                    end else begin
                        addr = ((wr_pos < cap) ? wr_pos : 0) + cap - n + it.read_index;
                        while (addr >= cap) addr -= cap;
                        res.sample_out = hist[addr];
                    end
                end
            end
            ACT_CLEAR: begin
                if (!running) begin
                    res.status = ST_NOT_RUNNING;
                end else begin
                    wr_pos   = 0;
                    fill_cnt = 0;
                end
            end
            ACT_RESUME: begin
                if (running) res.status = ST_ALREADY_RUN;
                else running = 1'b1;
            end
            ACT_PAUSE: begin
                if (!running) res.status = ST_ALREADY_PAUSED;
                else running = 1'b0;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item res;
        if (!i_rst_n) begin
            wr_pos     = 0;
            fill_cnt   = 0;
            running    = 1'b0;
            rate_reg   = RATE_RESET;
            window_reg = WINDOW_RESET;
            o_fails    = 0;
            due_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    report($sformatf("result %h with nothing expected", i_out_data));
                end else begin
                    want = due_results.pop_front();
                    if (i_out_data.status !== want.status)
                        report($sformatf("status %0d, expected %0d",
                                         i_out_data.status, want.status));
                    if (i_out_data.sample_out !== want.sample_out)
                        report($sformatf("sample_out %h, expected %h",
                                         i_out_data.sample_out, want.sample_out));
                    if (i_out_data.span_count !== want.span_count)
                        report($sformatf("span_count %0d, expected %0d",
                                         i_out_data.span_count, want.span_count));
                end
            end
            // A write to either register empties the ring; other indexes do nothing.
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_SAMPLE_RATE || i_cfg_index == CFG_WINDOW_MS) begin
                    if (i_cfg_index == CFG_SAMPLE_RATE) rate_reg = i_cfg_data;
                    else window_reg = i_cfg_data[MS_W-1:0];
                    wr_pos   = 0;
                    fill_cnt = 0;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_ring_item(i_in_data, res);
                due_results = {due_results, res};
            end
        end
        o_pending <= due_results.size();
    end

endmodule

[verif/tb.sv]
// Testbench top for the audio history ring buffer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
    import ahrb_pkg::*;

    // Action codes past pause have no meaning and must be ignored by the block.
    localparam logic [ACT_W-1:0]     ACT_UNUSED_LO = 3'd5;
    localparam logic [ACT_W-1:0]     ACT_UNUSED_HI = 3'd7;
    // A configuration index that names no register.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;
    // Idle cycles after the drain; more than the slowest item takes, so a safe margin.
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned DRAIN_GUARD   = 50000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [RATE_W-1:0]    i_cfg_data;

    int unsigned pending;
    int unsigned fails;
    // Chance in percent, per cycle, that the sender idles or the receiver stalls.
    int unsigned snd_pct = 0;
    int unsigned rcv_pct = 0;
    // The block's run flag as the stimulus sees it; only resume and pause move it.
    bit          run_est = 1'b0;

    audio_history_ring_buffer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    ring_history_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_fails     (fails)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The receiver decides afresh on every cycle whether to hold off the result.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rcv_pct);
    end

    // Offers one transaction after a random idle gap and returns at the edge that
    // accepts it. Valid stays high, so a following call can chain without a bubble.
    task automatic send_op(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] sample,
                           input logic [MS_W-1:0] span, input logic [IDX_W-1:0] idx);
        t_in_item it;
        it.action     = act;
        it.sample_in  = sample;
        it.span_ms    = span;
        it.read_index = idx;
        while ($urandom_range(99) < snd_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (act == ACT_RESUME) run_est = 1'b1;
        else if (act == ACT_PAUSE) run_est = 1'b0;
    endtask

    // Holds the write until it is taken, then drops valid for one cycle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stops offering input and waits until every result is out and the block is quiet.
    task automatic settle();
        int unsigned guard;
        guard = 0;
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (pending != 0 && guard < DRAIN_GUARD);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One configuration followed by random traffic. span_hi and idx_hi are chosen per
    // setting so that most reads land near the capacity and both sides of the span edge.
    task automatic run_phase(input logic [RATE_W-1:0] rate, input logic [RATE_W-1:0] win,
                             input int unsigned count, input int unsigned span_hi,
                             input int unsigned idx_hi, input int unsigned snd,
                             input int unsigned rcv);
        int unsigned       done;
        int unsigned       r;
        int unsigned       s;
        logic [ACT_W-1:0]  act;
        logic [MS_W-1:0]   span;
        logic [IDX_W-1:0]  idx;
        settle();
        snd_pct = snd;
        rcv_pct = rcv;
        write_reg(CFG_SAMPLE_RATE, rate);
        write_reg(CFG_WINDOW_MS, win);
        done = 0;
        while (done < count) begin
            r = $urandom_range(99);
            // Paused stretches are kept short so that most traffic reaches the ring.
            if (!run_est && $urandom_range(99) < 75) act = ACT_RESUME;
            else if (r < 48) act = ACT_WRITE;
            else if (r < 84) act = ACT_READ;
            else if (r < 86) act = ACT_CLEAR;
            else if (r < 89) act = ACT_PAUSE;
            else if (r < 93) act = ACT_RESUME;
            else if (r < 96) act = ACT_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
            else act = ACT_WRITE;
            s = $urandom_range(9);
            if (s < 3) span = '0;
            else if (s < 8) span = MS_W'($urandom_range(span_hi));
            else span = MS_W'($urandom);
            if ($urandom_range(9) < 8) idx = IDX_W'($urandom_range(idx_hi));
            else idx = IDX_W'($urandom);
            send_op(act, $urandom, span, idx);
            if (act < ACT_UNUSED_LO) done++;
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset settings: 16000 samples/s, 2000 ms window.
        // The block comes out of reset paused, so everything but resume is refused.
        send_op(ACT_READ, '0, '0, '0);
        send_op(ACT_WRITE, '1, '0, '0);
        send_op(ACT_CLEAR, '0, '0, '0);
        send_op(ACT_PAUSE, '0, '0, '0);
        send_op(ACT_RESUME, '0, '0, '0);
        send_op(ACT_RESUME, '0, '0, '0);
        // An empty ring gives a span of zero, so even index zero is outside it.
        send_op(ACT_READ, '0, '0, '0);
        send_op(ACT_WRITE, '0, '0, '0);
        send_op(ACT_WRITE, '1, '0, '0);
        send_op(ACT_WRITE, 32'hA5A5_5A5A, '0, '0);
        // Reads clamp to the fill of three; check oldest, newest, one past.
        send_op(ACT_READ, '0, '0, '0);
        send_op(ACT_READ, '0, '0, 15'd2);
        send_op(ACT_READ, '0, 14'd1, 15'd3);
        send_op(ACT_READ, '0, '1, '1);
        send_op(ACT_UNUSED_LO, '1, '1, '1);
        send_op(ACT_UNUSED_LO + 3'd1, '0, '0, '0);
        send_op(ACT_UNUSED_HI, '1, '1, '1);
        send_op(ACT_READ, '0, 14'd1, 15'd1);
        send_op(ACT_CLEAR, '0, '0, '0);
        send_op(ACT_READ, '0, '0, '0);
        send_op(ACT_WRITE, 32'h1234_5678, '0, '0);
        send_op(ACT_READ, '0, 14'd1, '0);
        send_op(ACT_PAUSE, '0, '0, '0);
        send_op(ACT_WRITE, 32'hDEAD_BEEF, '0, '0);
        send_op(ACT_RESUME, '0, '0, '0);

        // Random part. Small capacities make the ring wrap often; the extremes of both
        // registers come in along the way, including a zero rate where every span is
        // empty and a window word whose bits above the register width must be dropped.
        run_phase(18'd1000,   18'd7,                  300, 10,    9,   0,  0);
        run_phase(18'd1,      18'd16383,              250, 16383, 18,  69, 0);
        run_phase(18'd192000, 18'd1,                  250, 2,     200, 0,  69);
        run_phase(18'd0,      18'd500,                60,  16383, 3,   16, 16);
        run_phase(18'h3FFFF,  18'd16383,              200, 1,     300, 16, 16);
        run_phase(18'd1000,   18'd1,                  150, 3,     2,   0,  69);
        run_phase(18'd48000,  {4'hA, 14'd1},          300, 1,     50,  0,  0);

        // A write to an index that names no register must leave the ring as it is,
        // so the reads right after it still see the samples from before.
        settle();
        write_reg(CFG_UNUSED, RATE_W'($urandom));
        repeat (10) send_op(ACT_READ, '0, '0, IDX_W'($urandom_range(49)));

        run_phase(18'd3000,   18'd5,                  340, 6,     17,  69, 0);

        settle();
        if (fails == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this time.
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
